/* hdl/bcr_pkg.sv */
`timescale 1ns / 1ps

package bcr_pkg;

  // Defaults for the ramp geometry
  localparam int RAMP_WIDTH_DEF  = 16;
  localparam int RAMP_HEIGHT_DEF = 9;

  // Field widths
  localparam int COLOUR_W  = 16;
  localparam int COORD_W   = 4;
  localparam int RED_W     = 5;
  localparam int GREEN_W   = 6;
  localparam int BLUE_W    = 5;
  localparam int LEVEL_W   = 6;   // widest channel
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TOP_LEFT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_RIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_LEFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_RIGHT = 3'd3;

  // Corner slots
  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BL = 2'd2;
  localparam logic [1:0] CORNER_BR = 2'd3;

  // Channel slots
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef logic [COLOUR_W-1:0] colour_t;
  typedef logic [LEVEL_W-1:0]  level_t;

  // RGB565 channel extract, zero-extended to the widest channel
  function automatic level_t chan_level(input colour_t colour, input logic [1:0] ch);
    level_t lev;
    lev = '0;
    case (ch)
      CH_RED:   lev = {1'b0, colour[15:11]};
      CH_GREEN: lev = colour[10:5];
      CH_BLUE:  lev = {1'b0, colour[4:0]};
      default:  lev = '0;
    endcase
    return lev;
  endfunction

endpackage

/* hdl/bilinear_colour_ramp.sv */
`timescale 1ns / 1ps

// Bilinear RGB565 ramp: each transfer on the in_ side names a pixel (row, column) and
// produces one RGB565 pixel on the out_ side, interpolated from the four corner colours
// written on the cfg_ port (index 0..3 = top-left, top-right, bottom-left, bottom-right;
// other indexes are ignored). Rows and columns past the last one are clamped. Each
// channel is rounded half up. Throughput is one pixel per clock when the sink is ready;
// the stages are clamp, weight multiply, channel multiply, sum, and a reciprocal multiply
// that does the division by 2(W-1)(H-1). Backpressure stalls only the stages that hold
// data, so bubbles are squeezed out.
module bilinear_colour_ramp #(
  parameter int RAMP_WIDTH  = bcr_pkg::RAMP_WIDTH_DEF,
  parameter int RAMP_HEIGHT = bcr_pkg::RAMP_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [bcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcr_pkg::COLOUR_W-1:0]     cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bcr_pkg::IN_DATA_W-1:0]    in_tdata,   // pixel_row[3:0], pixel_column[7:4]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bcr_pkg::OUT_DATA_W-1:0]   out_tdata   // red_level[4:0], green_level[10:5],
                                                       // blue_level[15:11]
);

  localparam int WM1       = RAMP_WIDTH - 1;
  localparam int HM1       = RAMP_HEIGHT - 1;
  localparam int DEN       = WM1 * HM1;
  localparam int XW        = $clog2(RAMP_WIDTH);
  localparam int YW        = $clog2(RAMP_HEIGHT);
  localparam int DEN_W     = $clog2(DEN + 1);
  localparam int PROD_W    = DEN_W + bcr_pkg::LEVEL_W;
  localparam int N2_W      = DEN_W + bcr_pkg::LEVEL_W + 1;
  localparam int NS        = 5;
  // floor(n / DIV2) = (n * RECIP) >> SHIFT for every N2_W-bit n
  localparam int DIV2      = 2 * DEN;
  localparam int SHIFT     = N2_W + $clog2(DIV2);
  localparam int RECIP_W   = N2_W + 1;
  localparam int QP_W      = N2_W + RECIP_W;
  localparam logic [63:0] RECIP_64 = ((64'd1 << SHIFT) + 64'(DIV2) - 64'd1) / 64'(DIV2);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_64);

  // Corner colours
  bcr_pkg::colour_t colour_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) colour_r[k] <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bcr_pkg::REG_TOP_LEFT:     colour_r[bcr_pkg::CORNER_TL] <= cfg_data;
        bcr_pkg::REG_TOP_RIGHT:    colour_r[bcr_pkg::CORNER_TR] <= cfg_data;
        bcr_pkg::REG_BOTTOM_LEFT:  colour_r[bcr_pkg::CORNER_BL] <= cfg_data;
        bcr_pkg::REG_BOTTOM_RIGHT: colour_r[bcr_pkg::CORNER_BR] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage control: a stage advances when it is empty or the next one advances
  logic [NS-1:0] vld_r;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || out_tready;
    for (int i = NS - 2; i >= 0; i--) adv[i] = !vld_r[i] || adv[i+1];
  end

  assign in_tready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_tvalid;
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Stage 0: clamp coordinates, form complements
  logic [bcr_pkg::COORD_W-1:0] in_row, in_col;
  logic [XW-1:0] x_nxt, xc_nxt, x_r, xc_r;
  logic [YW-1:0] y_nxt, yc_nxt, y_r, yc_r;

  assign in_row = in_tdata[3:0];
  assign in_col = in_tdata[7:4];

  always_comb begin
    x_nxt  = (32'(in_col) > WM1) ? XW'(WM1) : XW'(in_col);
    y_nxt  = (32'(in_row) > HM1) ? YW'(HM1) : YW'(in_row);
    xc_nxt = XW'(WM1) - x_nxt;
    yc_nxt = YW'(HM1) - y_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x_r  <= x_nxt;
      xc_r <= xc_nxt;
      y_r  <= y_nxt;
      yc_r <= yc_nxt;
    end
  end

  // Stage 1: corner weights, summing to DEN
  logic [DEN_W-1:0] wt_r [4];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      wt_r[bcr_pkg::CORNER_TL] <= DEN_W'(xc_r) * DEN_W'(yc_r);
      wt_r[bcr_pkg::CORNER_TR] <= DEN_W'(x_r) * DEN_W'(yc_r);
      wt_r[bcr_pkg::CORNER_BL] <= DEN_W'(xc_r) * DEN_W'(y_r);
      wt_r[bcr_pkg::CORNER_BR] <= DEN_W'(x_r) * DEN_W'(y_r);
    end
  end

  // Stage 2: level times weight per channel and corner
  logic [PROD_W-1:0] prod_r [3][4];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 4; k++) begin
          prod_r[c][k] <= PROD_W'(bcr_pkg::chan_level(colour_r[k], 2'(c))) *
                          PROD_W'(wt_r[k]);
        end
      end
    end
  end

  // Stage 3: rounding numerator 2*num + DEN
  logic [N2_W-1:0] num2_r [3];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int c = 0; c < 3; c++) begin
        num2_r[c] <= ((N2_W'(prod_r[c][0]) + N2_W'(prod_r[c][1]) +
                       N2_W'(prod_r[c][2]) + N2_W'(prod_r[c][3])) << 1) + N2_W'(DEN);
      end
    end
  end

  // Stage 4: quotient by 2*DEN
  logic [bcr_pkg::LEVEL_W-1:0] quo_r [3];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int c = 0; c < 3; c++) begin
        quo_r[c] <= bcr_pkg::LEVEL_W'((QP_W'(num2_r[c]) * QP_W'(RECIP)) >> SHIFT);
      end
    end
  end

  assign out_tvalid = vld_r[NS-1];
  assign out_tdata  = {quo_r[bcr_pkg::CH_BLUE][bcr_pkg::BLUE_W-1:0],
                       quo_r[bcr_pkg::CH_GREEN][bcr_pkg::GREEN_W-1:0],
                       quo_r[bcr_pkg::CH_RED][bcr_pkg::RED_W-1:0]};

  // A stall on the input can only come from backpressure at the output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  // Red and blue quotients never need the sixth bit
  a_rb_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!quo_r[bcr_pkg::CH_RED][bcr_pkg::LEVEL_W-1] &&
                    !quo_r[bcr_pkg::CH_BLUE][bcr_pkg::LEVEL_W-1]))
    else $error("red or blue level overflow");

  // A result held off by the sink stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int RAMP_W      = bcr_pkg::RAMP_WIDTH_DEF;
  localparam int RAMP_H      = bcr_pkg::RAMP_HEIGHT_DEF;
  localparam int STALL_LIMIT = 5000;   // cycles with no transfer on either side
  localparam int DRAIN_WAIT  = 20;     // pipeline is 5 deep
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 128;

  // tdata order on the result side: red lowest, blue highest
  typedef struct packed {
    logic [bcr_pkg::BLUE_W-1:0]  blue;
    logic [bcr_pkg::GREEN_W-1:0] green;
    logic [bcr_pkg::RED_W-1:0]   red;
  } ramp_pixel_t;

  typedef struct {
    logic [bcr_pkg::COORD_W-1:0] row;
    logic [bcr_pkg::COORD_W-1:0] col;
  } pixel_coord_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_wr_en;
  logic [bcr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bcr_pkg::COLOUR_W-1:0]   cfg_data;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [bcr_pkg::IN_DATA_W-1:0]  in_tdata;     // pixel_row[3:0], pixel_column[7:4]
  logic                           out_tvalid;
  logic                           out_tready;
  logic [bcr_pkg::OUT_DATA_W-1:0] out_tdata;    // red_level[4:0], green_level[10:5],
                                                // blue_level[15:11]

  bcr_pkg::colour_t corner_colour [4];
  pixel_coord_t     pixel_queue[$];
  ramp_pixel_t      expected_pixels[$];

  int  queued_count;
  int  offered_count;
  int  accepted_count;
  int  checked_count;
  int  mismatches;
  int  stall_cycles;
  int  setting_count;
  int  in_gap;
  int  out_gap;
  int  hold_cnt;
  int  hold_requests;
  int  holds_served;
  bit  in_idle_en;
  bit  out_idle_en;

  bilinear_colour_ramp #(
    .RAMP_WIDTH  (RAMP_W),
    .RAMP_HEIGHT (RAMP_H)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Rounded-half-up blend of one channel across the four corners
  function automatic int blend_channel(input int shift, input int mask, input int wtl,
                                       input int wtr, input int wbl, input int wbr);
    int num;
    int den;
    den = (RAMP_W - 1) * (RAMP_H - 1);
    num = ((int'(corner_colour[bcr_pkg::CORNER_TL]) >> shift) & mask) * wtl
        + ((int'(corner_colour[bcr_pkg::CORNER_TR]) >> shift) & mask) * wtr
        + ((int'(corner_colour[bcr_pkg::CORNER_BL]) >> shift) & mask) * wbl
        + ((int'(corner_colour[bcr_pkg::CORNER_BR]) >> shift) & mask) * wbr;
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic ramp_pixel_t ramp_pixel(input logic [bcr_pkg::COORD_W-1:0] row,
                                             input logic [bcr_pkg::COORD_W-1:0] col);
    int x;
    int y;
    int wtl;
    int wtr;
    int wbl;
    int wbr;
    ramp_pixel_t p;
    y = int'(row);
    x = int'(col);
    if (y > RAMP_H - 1) y = RAMP_H - 1;
    if (x > RAMP_W - 1) x = RAMP_W - 1;
    wtl = (RAMP_W - 1 - x) * (RAMP_H - 1 - y);
    wtr = x * (RAMP_H - 1 - y);
    wbl = (RAMP_W - 1 - x) * y;
    wbr = x * y;
    p.red   = bcr_pkg::RED_W'(blend_channel(11, 'h1F, wtl, wtr, wbl, wbr));
    p.green = bcr_pkg::GREEN_W'(blend_channel(5, 'h3F, wtl, wtr, wbl, wbr));
    p.blue  = bcr_pkg::BLUE_W'(blend_channel(0, 'h1F, wtl, wtr, wbl, wbr));
    return p;
  endfunction

  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic bcr_pkg::colour_t random_colour();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return bcr_pkg::colour_t'($urandom);
    endcase
  endfunction

  // Pixel source; the offered item is outstanding until the monitor counts it
  always @(negedge clk) begin : drive_pixels
    logic                          nv;
    logic [bcr_pkg::IN_DATA_W-1:0] nd;
    pixel_coord_t                  item;
    nv = in_tvalid;
    nd = in_tdata;
    if (!rst_n) begin
      nv = 1'b0;
      nd = '0;
    end else if (!in_tvalid || accepted_count == offered_count) begin
      if (in_gap > 0) begin
        in_gap--;
        nv = 1'b0;
      end else if (pixel_queue.size() > 0) begin
        item = pixel_queue.pop_front();
        nd = {item.col, item.row};
        nv = 1'b1;
        offered_count++;
        in_gap = pick_gap(in_idle_en);
      end else begin
        nv = 1'b0;
      end
    end
    in_tvalid <= nv;
    in_tdata  <= nd;
  end

  // Pixel sink; a hold request stalls it for a long stretch
  always @(negedge clk) begin : drive_ready
    logic nr;
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_cnt = $urandom_range(150, 250);
    end
    if (!rst_n) begin
      nr = 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      nr = 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      nr = 1'b0;
    end else begin
      nr = 1'b1;
      out_gap = pick_gap(out_idle_en);
    end
    out_tready <= nr;
  end

  always @(posedge clk) begin : watch_ports
    ramp_pixel_t got;
    ramp_pixel_t want;
    bit          moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_pixels.push_back(ramp_pixel(in_tdata[3:0], in_tdata[7:4]));
        accepted_count++;
        moved = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        got = ramp_pixel_t'(out_tdata);
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $realtime,
                     got.red, got.green, got.blue);
        end else begin
          want = expected_pixels.pop_front();
          checked_count++;
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: pixel %0d expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       $realtime, checked_count, want.red, want.green, want.blue,
                       got.red, got.green, got.blue);
          end
        end
      end
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  task automatic cfg_write(input logic [bcr_pkg::CFG_IDX_W-1:0] idx,
                           input bcr_pkg::colour_t value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx <= bcr_pkg::REG_BOTTOM_RIGHT) corner_colour[idx[1:0]] = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_corners(input bcr_pkg::colour_t tl, input bcr_pkg::colour_t tr,
                             input bcr_pkg::colour_t bl, input bcr_pkg::colour_t br);
    cfg_write(bcr_pkg::REG_TOP_LEFT, tl);
    cfg_write(bcr_pkg::REG_TOP_RIGHT, tr);
    cfg_write(bcr_pkg::REG_BOTTOM_LEFT, bl);
    cfg_write(bcr_pkg::REG_BOTTOM_RIGHT, br);
    setting_count++;
  endtask

  // Call at a rising edge so the driver never races the queue
  task automatic queue_pixel(input int row, input int col);
    pixel_coord_t item;
    item.row = bcr_pkg::COORD_W'(row);
    item.col = bcr_pkg::COORD_W'(col);
    pixel_queue.push_back(item);
    queued_count++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_count != queued_count || expected_pixels.size() != 0);
  endtask

  initial begin : stimulus
    int k;
    int n;
    int row;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_idle_en   = 1'b1;
    out_idle_en  = 1'b1;
    for (k = 0; k < 4; k++) corner_colour[k] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Pure channel at each corner, white at bottom right
    set_corners(16'hF800, 16'h07E0, 16'h001F, 16'hFFFF);
    @(posedge clk);
    queue_pixel(0, 0);
    queue_pixel(0, RAMP_W - 1);
    queue_pixel(RAMP_H - 1, 0);
    queue_pixel(RAMP_H - 1, RAMP_W - 1);
    queue_pixel(4, 7);
    queue_pixel(4, 8);
    queue_pixel(1, 1);
    queue_pixel(7, 14);
    queue_pixel(9, 0);              // rows past the last one clamp
    queue_pixel(15, 15);
    queue_pixel(12, 5);
    wait_drained();

    // Indexes above the register list must leave the corners alone
    for (k = int'(bcr_pkg::REG_BOTTOM_RIGHT) + 1; k < (1 << bcr_pkg::CFG_IDX_W); k++)
      cfg_write(bcr_pkg::CFG_IDX_W'(k), bcr_pkg::colour_t'($urandom));
    @(posedge clk);
    queue_pixel(2, 3);
    queue_pixel(6, 10);
    wait_drained();

    set_corners(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    @(posedge clk);
    queue_pixel(0, 0);
    queue_pixel(5, 9);
    queue_pixel(15, 15);
    wait_drained();

    set_corners(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    @(posedge clk);
    queue_pixel(3, 4);
    queue_pixel(8, 15);
    queue_pixel(11, 2);
    wait_drained();

    for (k = 0; k < RAND_PHASES; k++) begin
      set_corners(random_colour(), random_colour(), random_colour(), random_colour());
      if ($urandom_range(0, 2) == 0)
        cfg_write(bcr_pkg::CFG_IDX_W'($urandom_range(int'(bcr_pkg::REG_BOTTOM_RIGHT) + 1,
                                                     (1 << bcr_pkg::CFG_IDX_W) - 1)),
                  bcr_pkg::colour_t'($urandom));
      @(posedge clk);
      in_idle_en  = (k % 3 != 0);
      out_idle_en = (k % 3 != 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 7) == 0) row = $urandom_range(RAMP_H, 15);
        else row = $urandom_range(0, RAMP_H - 1);
        queue_pixel(row, $urandom_range(0, 15));
      end
      // Sink stalls while the source keeps offering: pipeline fills and backs up
      if (k == 2 || k == 7) hold_requests++;
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $display("%0d pixels never came out", expected_pixels.size());
      mismatches += expected_pixels.size();
    end
    $display("Streamed %0d pixels over %0d corner settings,", accepted_count, setting_count);
    $display("clamped rows and stray indexes included; checked %0d pixels, %0d mismatches",
             checked_count, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
